FILE: src/data_literal_byte_parser_macros.svh
// Assertion macros for the data literal byte parser.
`ifndef DATA_LITERAL_BYTE_PARSER_MACROS_SVH
`define DATA_LITERAL_BYTE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define DLBP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlbp assertion failed");
`define DLBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlbp assertion failed");
`else
`define DLBP_ASSERT_SAME(label, clk, rst, ante, cons)
`define DLBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/dlbp_pkg.sv
package dlbp_pkg;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ESCAPE = 3'd1;
   localparam logic [2:0] ST_UNTERM_STR = 3'd2;
   localparam logic [2:0] ST_BAD_NUMBER = 3'd3;
   localparam logic [2:0] ST_RANGE      = 3'd4;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_BYTE,
      KIND_WORD
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] word;
      logic        neg;
      logic        done;
      logic [2:0]  status;
   } cmd_type;

endpackage

FILE: src/dlbp_front.sv
module dlbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        ch,
   input  logic              eol,
   output logic              push,
   output dlbp_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      MODE_BETWEEN,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_NUMBER,
      MODE_SKIP
   } mode_type;

   typedef enum logic [1:0] {
      STAGE_PREFIX,
      STAGE_SIGN,
      STAGE_DIGITS,
      STAGE_TAIL
   } stage_type;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;

   function automatic logic [8:0] escape_decode(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h6E:   r = {1'b1, 8'h0A};
         8'h74:   r = {1'b1, 8'h09};
         8'h72:   r = {1'b1, 8'h0D};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h22:   r = {1'b1, 8'h22};
         8'h30:   r = {1'b1, 8'h00};
         default: r = {1'b0, 8'h00};
      endcase
      return r;
   endfunction

   function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
      return (cur == dlbp_pkg::ST_OK) ? code : cur;
   endfunction

   mode_type    mode_ff, mode_in;
   stage_type   stage_ff, stage_in;
   logic        hex_ff, hex_in;
   logic        neg_ff, neg_in;
   logic        seen_ff, seen_in;
   logic [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [2:0]  err_ff, err_in;

   logic        is_ws;
   logic        hex_src;
   logic [63:0] acc_src;
   logic        dig_ok;
   logic [3:0]  dig;
   logic [67:0] prod;
   logic        run_num;
   logic        fin;
   logic        sign_skip;
   logic [8:0]  esc;

   assign is_ws   = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
   assign hex_src = (mode_ff == MODE_BETWEEN) ? 1'b0 : hex_ff;
   assign acc_src = (mode_ff == MODE_BETWEEN) ? 64'd0 : acc_ff;
   assign esc     = escape_decode(ch);

   always_comb begin
      dig_ok = 1'b0;
      dig    = 4'd0;
      if ((ch >= 8'h30) && (ch <= 8'h39)) begin
         dig_ok = 1'b1;
         dig    = 4'(ch - 8'h30);
      end else if (hex_src && (ch >= 8'h61) && (ch <= 8'h66)) begin
         dig_ok = 1'b1;
         dig    = 4'(ch - 8'h57);
      end else if (hex_src && (ch >= 8'h41) && (ch <= 8'h46)) begin
         dig_ok = 1'b1;
         dig    = 4'(ch - 8'h37);
      end
   end

   assign prod = (hex_src ? {acc_src, 4'b0000}
                          : ({1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0}))
               + {64'd0, dig};

   always_comb begin
      mode_in    = mode_ff;
      stage_in   = stage_ff;
      hex_in     = hex_ff;
      neg_in     = neg_ff;
      seen_in    = seen_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      err_in     = err_ff;
      cmd.kind   = dlbp_pkg::KIND_NONE;
      cmd.word   = 32'd0;
      cmd.neg    = 1'b0;
      cmd.done   = 1'b0;
      cmd.status = dlbp_pkg::ST_OK;
      run_num    = 1'b0;
      fin        = 1'b0;
      sign_skip  = 1'b0;

      unique case (mode_ff)
         MODE_BETWEEN: begin
            if (!is_ws) begin
               if (ch == CH_SEMI) begin
                  mode_in = MODE_SKIP;
               end else if (ch == CH_QUOTE) begin
                  mode_in = MODE_STRING;
               end else begin
                  mode_in = MODE_NUMBER;
                  hex_in  = 1'b0;
                  neg_in  = 1'b0;
                  seen_in = 1'b0;
                  acc_in  = 64'd0;
                  ovf_in  = 1'b0;
                  if (ch == CH_DOLLAR) begin
                     hex_in   = 1'b1;
                     stage_in = STAGE_SIGN;
                  end else if (ch == CH_HASH) begin
                     stage_in = STAGE_SIGN;
                  end else begin
                     stage_in = STAGE_DIGITS;
                     run_num  = 1'b1;
                  end
               end
            end
         end
         MODE_STRING: begin
            if (ch == CH_QUOTE) begin
               mode_in = MODE_BETWEEN;
            end else if (eol) begin
               err_in  = first_err(err_in, dlbp_pkg::ST_UNTERM_STR);
               mode_in = MODE_SKIP;
            end else if (ch == CH_BSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               cmd.kind = dlbp_pkg::KIND_BYTE;
               cmd.word = {24'd0, ch};
            end
         end
         MODE_ESCAPE: begin
            if (!esc[8]) begin
               err_in  = first_err(err_in, dlbp_pkg::ST_BAD_ESCAPE);
               mode_in = MODE_SKIP;
            end else if (eol) begin
               err_in  = first_err(err_in, dlbp_pkg::ST_UNTERM_STR);
               mode_in = MODE_SKIP;
            end else begin
               cmd.kind = dlbp_pkg::KIND_BYTE;
               cmd.word = {24'd0, esc[7:0]};
               mode_in  = MODE_STRING;
            end
         end
         MODE_NUMBER: begin
            if (is_ws) begin
               fin = 1'b1;
            end else begin
               run_num = 1'b1;
            end
         end
         MODE_SKIP: begin
         end
         default: begin
         end
      endcase

      if (run_num && (stage_in != STAGE_TAIL)) begin
         if (stage_in == STAGE_SIGN) begin
            stage_in = STAGE_DIGITS;
            if (ch == CH_MINUS) begin
               neg_in    = 1'b1;
               sign_skip = 1'b1;
            end
         end
         if (!sign_skip) begin
            if (!dig_ok) begin
               if (seen_in) begin
                  stage_in = STAGE_TAIL;
               end else begin
                  err_in  = first_err(err_in, dlbp_pkg::ST_BAD_NUMBER);
                  mode_in = MODE_SKIP;
               end
            end else begin
               seen_in = 1'b1;
               if (prod[67:64] != 4'd0) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = prod[63:0];
               end
            end
         end
      end

      if (fin || (eol && (mode_in == MODE_NUMBER))) begin
         if (!seen_in) begin
            err_in  = first_err(err_in, dlbp_pkg::ST_BAD_NUMBER);
            mode_in = MODE_SKIP;
         end else if (ovf_in) begin
            err_in  = first_err(err_in, dlbp_pkg::ST_RANGE);
            mode_in = MODE_SKIP;
         end else begin
            cmd.kind = dlbp_pkg::KIND_WORD;
            cmd.word = acc_in[31:0];
            cmd.neg  = neg_in;
            mode_in  = MODE_BETWEEN;
            stage_in = STAGE_PREFIX;
         end
      end

      if (eol) begin
         if ((mode_in == MODE_STRING) || (mode_in == MODE_ESCAPE)) begin
            err_in = first_err(err_in, dlbp_pkg::ST_UNTERM_STR);
         end
         cmd.done   = 1'b1;
         cmd.status = err_in;
         mode_in    = MODE_BETWEEN;
         stage_in   = STAGE_PREFIX;
         hex_in     = 1'b0;
         neg_in     = 1'b0;
         seen_in    = 1'b0;
         acc_in     = 64'd0;
         ovf_in     = 1'b0;
         err_in     = dlbp_pkg::ST_OK;
      end
   end

   assign push = accept && ((cmd.kind != dlbp_pkg::KIND_NONE) || cmd.done);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BETWEEN;
         stage_ff <= STAGE_PREFIX;
         hex_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         err_ff   <= dlbp_pkg::ST_OK;
      end else if (accept) begin
         mode_ff  <= mode_in;
         stage_ff <= stage_in;
         hex_ff   <= hex_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
         ovf_ff   <= ovf_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: src/dlbp_queue.sv
module dlbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dlbp_pkg::cmd_type push_cmd,
   input  logic              pop,
   output dlbp_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   dlbp_pkg::cmd_type                 q_mem_ff [dlbp_pkg::QDEPTH];
   logic [dlbp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dlbp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dlbp_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == dlbp_pkg::QCNT_W'(dlbp_pkg::QDEPTH));
   assign head  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dlbp_pkg::QPTR_W'(dlbp_pkg::QDEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dlbp_pkg::QPTR_W'(dlbp_pkg::QDEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/dlbp_back.sv
module dlbp_back (
   input  logic              clock,
   input  logic              reset,
   input  dlbp_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic        active_ff, active_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [2:0]  status_ff, status_in;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]  rsp_tuser_ff, rsp_tuser_in;
   logic        rsp_tlast_ff, rsp_tlast_in;

   logic        have;
   logic        load_out;
   logic [31:0] v_word;
   logic [31:0] head_word;
   logic [2:0]  v_cnt;
   logic [2:0]  head_cnt;
   logic        v_done;
   logic [2:0]  v_status;
   logic        finished;

   always_comb begin
      unique case (head.kind)
         dlbp_pkg::KIND_BYTE: head_cnt = 3'd1;
         dlbp_pkg::KIND_WORD: head_cnt = 3'd4;
         default:             head_cnt = 3'd0;
      endcase
   end

   assign head_word = head.neg ? (32'd0 - head.word) : head.word;
   assign have      = active_ff || !empty;
   assign load_out  = have && (!rsp_tvalid_ff || rsp_tready);
   assign v_word    = active_ff ? word_ff   : head_word;
   assign v_cnt     = active_ff ? cnt_ff    : head_cnt;
   assign v_done    = active_ff ? done_ff   : head.done;
   assign v_status  = active_ff ? status_ff : head.status;
   assign pop       = load_out && !active_ff;

   always_comb begin
      active_in     = active_ff;
      word_in       = word_ff;
      cnt_in        = cnt_ff;
      done_in       = done_ff;
      status_in     = status_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      finished      = 1'b0;
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
         if (v_cnt != 3'd0) begin
            rsp_tdata_in = {8'd0, v_word[7:0]};
            rsp_tuser_in = 2'b01;
            finished     = (v_cnt == 3'd1) && !v_done;
         end else begin
            rsp_tdata_in = {5'd0, v_status, 8'd0};
            rsp_tuser_in = 2'b10;
            finished     = 1'b1;
         end
         rsp_tlast_in = finished;
         active_in    = !finished;
         word_in      = {8'd0, v_word[31:8]};
         cnt_in       = (v_cnt != 3'd0) ? v_cnt - 3'd1 : 3'd0;
         done_in      = v_done;
         status_in    = v_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      cnt_ff       <= cnt_in;
      done_ff      <= done_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

FILE: src/data_literal_byte_parser.sv
// Channel  | Ports   | Content
// input    | req_*   | one character of a data line; tlast on the final character
// result   | rsp_*   | one byte or the closing status of a line; tlast ends a run
//
// A character is taken whenever the command queue has room.
// The result side emits one transaction per cycle while rsp_tready is high:
// a string byte takes one, a finished number four, the status of a line one more.
// Sustained rate is set by the results per character: a two-character number
// token yields four result transactions, two per character.
// Reset is synchronous and clears the parser state and the queue.
// Either side may stall; the command queue lets the other side run on.
`include "data_literal_byte_parser_macros.svh"

module data_literal_byte_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [10:8] status
   output logic [1:0]  rsp_tuser,   // [0] has_byte, [1] line_done
   output logic        rsp_tlast
);

   logic              accept;
   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic              q_full;
   logic              rsp_status_ok;
   dlbp_pkg::cmd_type f_cmd;
   dlbp_pkg::cmd_type q_head;

   assign req_tready    = !q_full;
   assign accept        = req_tvalid && req_tready;
   assign rsp_status_ok = (rsp_tdata[10:8] == dlbp_pkg::ST_OK);

   dlbp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_tdata),
      .eol    (req_tlast),
      .push   (q_push),
      .cmd    (f_cmd)
   );

   dlbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (f_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   dlbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `DLBP_ASSERT_SAME(a_status_closes_run, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast)
   `DLBP_ASSERT_SAME(a_byte_status_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_status_ok)
   `DLBP_ASSERT_SAME(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `DLBP_ASSERT_NEXT(a_eol_pushes, clock, reset, accept && req_tlast, !q_empty)

endmodule

FILE: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD          = 20;
   localparam int RANDOM_ITEMS    = 195;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 1000;

   localparam logic [7:0] CH_HEX       = "$";
   localparam logic [7:0] CH_DEC       = "#";
   localparam logic [7:0] CH_COMMENT   = ";";
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS     = "-";
   localparam logic [7:0] CH_PLUS      = "+";
   localparam logic [47:0] SPACE_CHARS = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   localparam logic [47:0] ESC_CHARS   = {"n", "t", "r", CH_BACKSLASH, CH_QUOTE, "0"};

   typedef enum logic [2:0] {PM_GAP, PM_TEXT, PM_ESC, PM_NUM, PM_IGNORE} scan_mode_type;
   typedef enum logic [1:0] {NS_PREFIX, NS_SIGN, NS_DIGITS, NS_TAIL} num_stage_type;

   typedef struct packed {
      logic [7:0] value;
      logic       has_byte;
      logic       line_done;
      logic [2:0] status;
      logic       run_last;
   } parse_result_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
      logic       pinned;
      logic [2:0] pinned_status;
   } char_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] ch
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] data_byte, [10:8] status
   logic [1:0]  rsp_tuser;   // [0] has_byte, [1] line_done
   logic        rsp_tlast;

   scan_mode_type scan_mode;
   num_stage_type num_stage;
   logic          num_hex;
   logic          num_neg;
   logic          num_seen;
   logic [63:0]   num_acc;
   logic          num_ovf;
   logic [2:0]    line_status;

   parse_result_type step_results[$];
   parse_result_type predicted_q[$];
   char_row_type     char_rows[$];
   int               chars_taken = 0;
   int               failures = 0;
   int               quiet_cycles = 0;

   char_row_type directed_rows [25] = '{
      '{CH_HEX, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_MINUS, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"1", 1'b1, 1'b1, dlbp_pkg::ST_OK},
      '{CH_QUOTE, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_BACKSLASH, 1'b1, 1'b1, dlbp_pkg::ST_UNTERM_STR},
      '{CH_QUOTE, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_BACKSLASH, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"q", 1'b1, 1'b1, dlbp_pkg::ST_BAD_ESCAPE},
      '{CH_DEC, 1'b1, 1'b1, dlbp_pkg::ST_BAD_NUMBER},
      '{CH_COMMENT, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{" ", 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"x", 1'b1, 1'b1, dlbp_pkg::ST_OK},
      '{CH_QUOTE, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"A", 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_QUOTE, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"9", 1'b1, 1'b1, dlbp_pkg::ST_OK},
      '{8'hFF, 1'b1, 1'b1, dlbp_pkg::ST_BAD_NUMBER},
      '{8'h00, 1'b1, 1'b1, dlbp_pkg::ST_BAD_NUMBER},
      '{CH_MINUS, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"5", 1'b1, 1'b1, dlbp_pkg::ST_BAD_NUMBER},
      '{8'h09, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_QUOTE, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_BACKSLASH, 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{"0", 1'b0, 1'b0, dlbp_pkg::ST_OK},
      '{CH_QUOTE, 1'b1, 1'b1, dlbp_pkg::ST_OK}
   };

   data_literal_byte_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #(PERIOD / 2) clock = ~clock;

   function automatic bit is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 'h30;
      if (num_hex) begin
         if (c >= "a" && c <= "f") return int'(c) - 'h61 + 10;
         if (c >= "A" && c <= "F") return int'(c) - 'h41 + 10;
      end
      return -1;
   endfunction

   task automatic clear_state();
      scan_mode   = PM_GAP;
      num_stage   = NS_PREFIX;
      num_hex     = 1'b0;
      num_neg     = 1'b0;
      num_seen    = 1'b0;
      num_acc     = '0;
      num_ovf     = 1'b0;
      line_status = dlbp_pkg::ST_OK;
   endtask

   task automatic emit(input logic [7:0] b, input logic has, input logic done,
                       input logic [2:0] st);
      parse_result_type r;
      r.value     = b;
      r.has_byte  = has;
      r.line_done = done;
      r.status    = st;
      r.run_last  = 1'b0;
      step_results.insert(step_results.size(), r);
   endtask

   task automatic raise(input logic [2:0] code);
      if (line_status == dlbp_pkg::ST_OK) line_status = code;
      scan_mode = PM_IGNORE;
   endtask

   task automatic feed_digit(input logic [7:0] c);
      int          d;
      logic [63:0] radix;
      logic [63:0] dv;
      if (num_stage == NS_TAIL) return;
      if (num_stage == NS_SIGN) begin
         num_stage = NS_DIGITS;
         if (c == CH_MINUS) begin
            num_neg = 1'b1;
            return;
         end
      end
      d = digit_of(c);
      if (d < 0) begin
         if (num_seen) num_stage = NS_TAIL;
         else raise(dlbp_pkg::ST_BAD_NUMBER);
         return;
      end
      radix = num_hex ? 64'd16 : 64'd10;
      dv = 64'(d);
      num_seen = 1'b1;
      if (num_acc > (~64'd0 - dv) / radix) num_ovf = 1'b1;
      else num_acc = num_acc * radix + dv;
   endtask

   task automatic open_number(input logic [7:0] c);
      scan_mode = PM_NUM;
      num_hex   = 1'b0;
      num_neg   = 1'b0;
      num_seen  = 1'b0;
      num_acc   = '0;
      num_ovf   = 1'b0;
      if (c == CH_HEX) begin
         num_hex = 1'b1;
         num_stage = NS_SIGN;
      end else if (c == CH_DEC) begin
         num_stage = NS_SIGN;
      end else begin
         num_stage = NS_DIGITS;
         feed_digit(c);
      end
   endtask

   task automatic close_number();
      logic [31:0] v;
      if (!num_seen) begin
         raise(dlbp_pkg::ST_BAD_NUMBER);
         return;
      end
      if (num_ovf) begin
         raise(dlbp_pkg::ST_RANGE);
         return;
      end
      v = num_acc[31:0];
      if (num_neg) v = 32'd0 - v;
      for (int i = 0; i < 4; i++) emit(v[8*i +: 8], 1'b1, 1'b0, dlbp_pkg::ST_OK);
      scan_mode = PM_GAP;
      num_stage = NS_PREFIX;
   endtask

   task automatic parse_char(input logic [7:0] c, input logic eol, input logic pinned,
                             input logic [2:0] pinned_status);
      logic [7:0]       esc;
      logic             esc_ok;
      parse_result_type r;
      step_results.delete();
      case (scan_mode)
         PM_GAP: begin
            if (!is_space(c)) begin
               if (c == CH_COMMENT) scan_mode = PM_IGNORE;
               else if (c == CH_QUOTE) scan_mode = PM_TEXT;
               else open_number(c);
            end
         end
         PM_TEXT: begin
            if (c == CH_QUOTE) scan_mode = PM_GAP;
            else if (eol) raise(dlbp_pkg::ST_UNTERM_STR);
            else if (c == CH_BACKSLASH) scan_mode = PM_ESC;
            else emit(c, 1'b1, 1'b0, dlbp_pkg::ST_OK);
         end
         PM_ESC: begin
            esc_ok = 1'b1;
            esc = 8'h00;
            case (c)
               "n":          esc = 8'h0A;
               "t":          esc = 8'h09;
               "r":          esc = 8'h0D;
               CH_BACKSLASH: esc = CH_BACKSLASH;
               CH_QUOTE:     esc = CH_QUOTE;
               "0":          esc = 8'h00;
               default:      esc_ok = 1'b0;
            endcase
            if (!esc_ok) raise(dlbp_pkg::ST_BAD_ESCAPE);
            else if (eol) raise(dlbp_pkg::ST_UNTERM_STR);
            else begin
               emit(esc, 1'b1, 1'b0, dlbp_pkg::ST_OK);
               scan_mode = PM_TEXT;
            end
         end
         PM_NUM: begin
            if (is_space(c)) close_number();
            else feed_digit(c);
         end
         default: ;
      endcase
      if (eol) begin
         if (scan_mode == PM_NUM) close_number();
         else if (scan_mode == PM_TEXT || scan_mode == PM_ESC) raise(dlbp_pkg::ST_UNTERM_STR);
         emit(8'h00, 1'b0, 1'b1, pinned ? pinned_status : line_status);
         clear_state();
      end
      if (step_results.size() > 0) begin
         r = step_results.pop_back();
         r.run_last = 1'b1;
         step_results.insert(step_results.size(), r);
      end
      foreach (step_results[i]) predicted_q.insert(predicted_q.size(), step_results[i]);
   endtask

   function automatic logic [7:0] pick_space();
      return SPACE_CHARS[8 * $urandom_range(0, 5) +: 8];
   endfunction

   function automatic logic [7:0] digit_char(input bit hex_digits);
      int d;
      d = hex_digits ? $urandom_range(0, 15) : $urandom_range(0, 9);
      if (d < 10) return 8'(8'h30 + d);
      return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
   endfunction

   task automatic build_line();
      logic [7:0]   line_q[$];
      logic [7:0]   c;
      int           tokens;
      int           prefix;
      int           digits;
      char_row_type row;
      tokens = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) line_q.insert(line_q.size(), pick_space());
      for (int t = 0; t < tokens; t++) begin
         if (t > 0 && $urandom_range(0, 9) != 0)
            repeat ($urandom_range(1, 2)) line_q.insert(line_q.size(), pick_space());
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               prefix = $urandom_range(0, 2);
               if (prefix == 1) line_q.insert(line_q.size(), CH_HEX);
               else if (prefix == 2) line_q.insert(line_q.size(), CH_DEC);
               if ((prefix != 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0))
                  line_q.insert(line_q.size(),
                                ($urandom_range(0, 3) != 0) ? CH_MINUS : CH_PLUS);
               digits = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 21)
                                                    : $urandom_range(1, 6);
               if (prefix != 0 && $urandom_range(0, 11) == 0) digits = 0;
               repeat (digits) line_q.insert(line_q.size(), digit_char(prefix == 1));
               if ($urandom_range(0, 6) == 0)
                  line_q.insert(line_q.size(), 8'($urandom_range(8'h21, 8'h7E)));
            end
            4, 5, 6, 7: begin
               line_q.insert(line_q.size(), CH_QUOTE);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     line_q.insert(line_q.size(), CH_BACKSLASH);
                     if ($urandom_range(0, 4) == 0)
                        line_q.insert(line_q.size(), 8'($urandom_range(8'h21, 8'h7E)));
                     else
                        line_q.insert(line_q.size(), ESC_CHARS[8 * $urandom_range(0, 5) +: 8]);
                  end else begin
                     do c = 8'($urandom_range(1, 255));
                     while (c == CH_QUOTE || c == CH_BACKSLASH);
                     line_q.insert(line_q.size(), c);
                  end
               end
               if ($urandom_range(0, 6) != 0) line_q.insert(line_q.size(), CH_QUOTE);
            end
            8: begin
               line_q.insert(line_q.size(), CH_COMMENT);
               repeat ($urandom_range(0, 4))
                  line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
            end
            default: begin
               repeat ($urandom_range(1, 3))
                  line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
            end
         endcase
      end
      foreach (line_q[i]) begin
         row.ch            = line_q[i];
         row.eol           = (i == line_q.size() - 1);
         row.pinned        = 1'b0;
         row.pinned_status = dlbp_pkg::ST_OK;
         char_rows.insert(char_rows.size(), row);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_char(input char_row_type row);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.ch;
      req_tlast  <= row.eol;
      do @(posedge clock); while (!req_tready);
      chars_taken++;
      parse_char(row.ch, row.eol, row.pinned, row.pinned_status);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      clear_state();
      foreach (directed_rows[i]) char_rows.insert(char_rows.size(), directed_rows[i]);
      while (char_rows.size() < $size(directed_rows) + RANDOM_ITEMS) build_line();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (char_rows[i]) send_char(char_rows[i]);
      req_tvalid <= 1'b0;
      while (predicted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int span;
      bit squeezed;
      squeezed = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!squeezed && chars_taken >= 80) begin
            squeezed = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (span) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         span = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_q.size() == 0) begin
            $error("unexpected result transaction: tdata %0h tuser %0h tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            failures++;
         end else begin
            want = predicted_q.pop_front();
            if (rsp_tdata[7:0] !== want.value) begin
               $error("data_byte: expected %0h, got %0h", want.value, rsp_tdata[7:0]);
               failures++;
            end
            if (rsp_tdata[10:8] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[10:8]);
               failures++;
            end
            if (rsp_tdata[15:11] !== 5'd0) begin
               $error("tdata padding: expected 0, got %0h", rsp_tdata[15:11]);
               failures++;
            end
            if (rsp_tuser[0] !== want.has_byte) begin
               $error("has_byte: expected %0b, got %0b", want.has_byte, rsp_tuser[0]);
               failures++;
            end
            if (rsp_tuser[1] !== want.line_done) begin
               $error("line_done: expected %0b, got %0b", want.line_done, rsp_tuser[1]);
               failures++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: filelist.f
+incdir+src
src/dlbp_pkg.sv
src/dlbp_front.sv
src/dlbp_queue.sv
src/dlbp_back.sv
src/data_literal_byte_parser.sv
bench/testbench.sv
